@@ hdl/ric_pkg.sv @@
// Package for the readiness interest table: item structs, codes, cell-chain types.
// No dependencies; used by every other file in hdl/.
`timescale 1ns / 1ps
package ric_pkg;

  localparam int unsigned FD_COUNT         = 64;
  localparam int unsigned FD_W             = 6;
  localparam int unsigned MASK_W           = 32;
  localparam int unsigned DEF_SET_COUNT    = 8;
  localparam int unsigned DEF_SET_ENTRIES  = 32;

  typedef enum logic [2:0] {
    MODE_SET_READY = 3'd0,
    MODE_POLL      = 3'd1,
    MODE_CREATE    = 3'd2,
    MODE_ADD       = 3'd3,
    MODE_MODIFY    = 3'd4,
    MODE_DELETE    = 3'd5,
    MODE_WAIT      = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADARG   = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_NOSET    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_TERM
  } state_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [3:0]        set_id;
    logic [6:0]        fd;
    logic [MASK_W-1:0] events_mask;
    logic [5:0]        max_count;
    logic              last_element;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [2:0]        new_set;
    logic [5:0]        ready_fd;
    logic [MASK_W-1:0] hit_events;
    logic [7:0]        count;
    logic              has_entry;
    logic              end_of_run;
  } res_t;

  typedef struct packed {
    logic [FD_W-1:0]   fd;
    logic [MASK_W-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic vld;
    logic found;
  } tok_t;

  typedef struct packed {
    logic   act;
    entry_t ent;
  } rpt_t;

  typedef struct packed {
    mode_e             op;
    logic [6:0]        fd;
    logic [MASK_W-1:0] mask;
  } ctl_t;

endpackage

@@ hdl/ric_cell.sv @@
// One list slot of every interest set; passes the scan token to its neighbor.
// Depends on ric_pkg.
`timescale 1ns / 1ps
module ric_cell import ric_pkg::*; #(
  parameter int unsigned SET_COUNT   = DEF_SET_COUNT,
  parameter int unsigned SET_ENTRIES = DEF_SET_ENTRIES,
  parameter int unsigned CELL_IDX    = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  ctl_t                                  ctl_i,
  input  logic [(SET_COUNT > 1 ? $clog2(SET_COUNT) : 1)-1:0] set_i,
  input  logic [$clog2(SET_ENTRIES+1)-1:0]      len_i,
  input  logic                                  app_we_i,
  input  tok_t                                  tok_i,
  output tok_t                                  tok_o,
  input  entry_t                                nb_i,
  output entry_t                                ent_o,
  output rpt_t                                  rpt_o
);
  localparam int unsigned LW = $clog2(SET_ENTRIES+1);

  logic [FD_W-1:0]   fd_q   [SET_COUNT];
  logic [MASK_W-1:0] mask_q [SET_COUNT];
  entry_t cur;
  logic   active, nxt_ok, match, first, mod_we, shift_we, app_hit;
  tok_t   tok_q;

  assign cur.fd   = fd_q[set_i];
  assign cur.mask = mask_q[set_i];
  assign ent_o    = cur;

  assign active   = (LW+1)'(CELL_IDX) < {1'b0, len_i};
  assign nxt_ok   = (LW+1)'(CELL_IDX + 1) < {1'b0, len_i};
  assign match    = tok_i.vld && active && ({1'b0, cur.fd} == ctl_i.fd);
  assign first    = match && !tok_i.found;
  assign mod_we   = (ctl_i.op == MODE_MODIFY) && first;
  // pull the upper neighbor down from the deleted slot upward
  assign shift_we = (ctl_i.op == MODE_DELETE) && tok_i.vld && (tok_i.found || match) && nxt_ok;
  assign app_hit  = app_we_i && (len_i == LW'(CELL_IDX));

  always_ff @(posedge clk_i) begin
    if (shift_we) begin
      fd_q[set_i]   <= nb_i.fd;
      mask_q[set_i] <= nb_i.mask;
    end else if (app_hit) begin
      fd_q[set_i]   <= ctl_i.fd[FD_W-1:0];
      mask_q[set_i] <= ctl_i.mask;
    end else if (mod_we) begin
      mask_q[set_i] <= ctl_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.vld   <= tok_i.vld;
      tok_q.found <= tok_i.found | match;
    end
  end

  assign tok_o     = tok_q;
  assign rpt_o.act = tok_i.vld && active;
  assign rpt_o.ent = tok_i.vld ? cur : '0;

endmodule

@@ hdl/readiness_interest_table_core.sv @@
// Top level of the readiness interest table: command sequencer, readiness store,
// and a chain of ric_cell list slots. Depends on ric_pkg and ric_cell.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low. Set ready, poll, create
// and every rejected item give one result. Add, modify, delete and wait send a
// token down the chain of SET_ENTRIES cells, one cell per cycle, so the chain
// length sets how long they take. Wait gives one result per ready entry, up to
// max_count, while the token travels, then one count result. Results show for
// exactly one cycle on result_valid_o and cannot be held off, so capture them as
// they come. Readiness words read as zero until first written.
module readiness_interest_table_core import ric_pkg::*; #(
  parameter int unsigned SET_COUNT   = DEF_SET_COUNT,
  parameter int unsigned SET_ENTRIES = DEF_SET_ENTRIES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic result_valid_o,
  output res_t res_o
);
  localparam int unsigned SW = SET_COUNT > 1 ? $clog2(SET_COUNT) : 1;
  localparam int unsigned LW = $clog2(SET_ENTRIES+1);

  state_e state_q, state_d;
  req_t   cmd_q;
  res_t   res_q, res_d;
  logic   res_vld_q, res_vld_d;

  // set table
  logic          in_use_q [SET_COUNT];
  logic [LW-1:0] len_q    [SET_COUNT];
  logic [SW-1:0] sidx, free_idx;
  logic [LW-1:0] cur_len;
  logic          set_ok, fd_ok, free_ok;
  logic          create_we, len_inc, len_dec;

  // readiness store
  logic [MASK_W-1:0]   rdy_mem [FD_COUNT];
  logic [FD_COUNT-1:0] rdy_vld_q;
  logic [MASK_W-1:0]   rd_q;
  logic                rd_vld_q, rw_we;
  logic [FD_W-1:0]     rd_addr;

  // cell chain
  tok_t   tok [SET_ENTRIES+1];
  entry_t ent [SET_ENTRIES+1];
  rpt_t   rpt [SET_ENTRIES];
  rpt_t   rpt_any;
  ctl_t   ctl;
  logic   inj, app_we;

  // wait stage and counters
  logic              stg_act_q;
  logic [FD_W-1:0]   stg_fd_q;
  logic [MASK_W-1:0] stg_mask_q;
  logic [MASK_W-1:0] stg_hit, poll_hit;
  logic [5:0]        n_q, n_d;
  logic [7:0]        hits_q, hits_d, hits_cnt;

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = res_vld_q;
  assign res_o          = res_q;

  assign sidx    = SW'(cmd_q.set_id);
  assign cur_len = len_q[sidx];
  assign set_ok  = (32'(cmd_q.set_id) < SET_COUNT) && in_use_q[sidx];
  assign fd_ok   = 32'(cmd_q.fd) < FD_COUNT;

  // lowest free set slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SET_COUNT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // chain of list slots; the token enters cell 0 and moves up one cell a cycle
  assign ctl.op   = mode_e'(cmd_q.mode);
  assign ctl.fd   = cmd_q.fd;
  assign ctl.mask = cmd_q.events_mask;
  assign tok[0].vld   = inj;
  assign tok[0].found = 1'b0;
  assign ent[SET_ENTRIES] = '0;

  for (genvar g = 0; g < SET_ENTRIES; g++) begin : g_cell
    ric_cell #(
      .SET_COUNT   (SET_COUNT),
      .SET_ENTRIES (SET_ENTRIES),
      .CELL_IDX    (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .set_i    (sidx),
      .len_i    (cur_len),
      .app_we_i (app_we),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .nb_i     (ent[g+1]),
      .ent_o    (ent[g]),
      .rpt_o    (rpt[g])
    );
  end

  // only the cell holding the token drives a nonzero report
  always_comb begin
    rpt_any = '0;
    for (int i = 0; i < SET_ENTRIES; i++) begin
      rpt_any = rpt_t'(rpt_any | rpt[i]);
    end
  end

  // readiness store: read the item's fd on accept, the slot's fd during a scan
  assign rd_addr = rpt_any.act ? rpt_any.ent.fd : req_i.fd[FD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rw_we) begin
      rdy_mem[cmd_q.fd[FD_W-1:0]] <= cmd_q.events_mask;
    end
    rd_q <= rdy_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (rw_we) begin
        rdy_vld_q[cmd_q.fd[FD_W-1:0]] <= 1'b1;
      end
      rd_vld_q <= rdy_vld_q[rd_addr];
    end
  end

  assign stg_hit  = (rd_vld_q ? rd_q : '0) & stg_mask_q;
  assign poll_hit = (fd_ok && rd_vld_q) ? (rd_q & cmd_q.events_mask) : '0;
  assign hits_cnt = (poll_hit != '0 && hits_q != 8'hFF) ? hits_q + 8'd1 : hits_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    res_d     = '0;
    res_vld_d = 1'b0;
    inj       = 1'b0;
    app_we    = 1'b0;
    rw_we     = 1'b0;
    create_we = 1'b0;
    len_inc   = 1'b0;
    len_dec   = 1'b0;
    hits_d    = hits_q;
    n_d       = n_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d          = S_IDLE;
        res_vld_d        = 1'b1;
        res_d.end_of_run = 1'b1;
        res_d.status     = ST_OK;
        unique case (cmd_q.mode)
          MODE_SET_READY: begin
            if (fd_ok) begin
              rw_we = 1'b1;
            end else begin
              res_d.status = ST_BADARG;
            end
          end
          MODE_POLL: begin
            res_d.hit_events = poll_hit;
            res_d.count      = hits_cnt;
            hits_d           = cmd_q.last_element ? 8'd0 : hits_cnt;
          end
          MODE_CREATE: begin
            if (free_ok) begin
              create_we     = 1'b1;
              res_d.new_set = 3'(free_idx);
            end else begin
              res_d.status = ST_NOSET;
            end
          end
          MODE_ADD: begin
            if (!set_ok || !fd_ok) begin
              res_d.status = ST_BADARG;
            end else begin
              res_vld_d = 1'b0;
              inj       = 1'b1;
              state_d   = S_SCAN;
            end
          end
          MODE_MODIFY, MODE_DELETE: begin
            if (!set_ok) begin
              res_d.status = ST_BADARG;
            end else begin
              res_vld_d = 1'b0;
              inj       = 1'b1;
              state_d   = S_SCAN;
            end
          end
          MODE_WAIT: begin
            if (!set_ok || cmd_q.max_count == 6'd0) begin
              res_d.status = ST_BADARG;
            end else begin
              res_vld_d = 1'b0;
              inj       = 1'b1;
              n_d       = '0;
              state_d   = S_SCAN;
            end
          end
          default: res_d.status = ST_BADARG;
        endcase
      end
      S_SCAN: begin
        // report a ready wait entry from the stage registered behind its cell, up to max_count
        if (stg_act_q && stg_hit != '0 && n_q < cmd_q.max_count) begin
          res_vld_d        = 1'b1;
          res_d.status     = ST_OK;
          res_d.has_entry  = 1'b1;
          res_d.ready_fd   = stg_fd_q;
          res_d.hit_events = stg_hit;
          n_d              = n_q + 6'd1;
        end
        if (tok[SET_ENTRIES].vld) begin
          if (cmd_q.mode == MODE_WAIT) begin
            state_d = S_TERM;
          end else begin
            state_d          = S_IDLE;
            res_vld_d        = 1'b1;
            res_d.end_of_run = 1'b1;
            res_d.status     = ST_OK;
            if (cmd_q.mode == MODE_ADD) begin
              if (tok[SET_ENTRIES].found) begin
                res_d.status = ST_DUP;
              end else if (32'(cur_len) >= SET_ENTRIES) begin
                res_d.status = ST_FULL;
              end else begin
                app_we  = 1'b1;
                len_inc = 1'b1;
              end
            end else if (!tok[SET_ENTRIES].found) begin
              res_d.status = ST_NOTFOUND;
            end else if (cmd_q.mode == MODE_DELETE) begin
              len_dec = 1'b1;
            end
          end
        end
      end
      S_TERM: begin
        state_d          = S_IDLE;
        res_vld_d        = 1'b1;
        res_d.status     = ST_OK;
        res_d.count      = 8'(n_q);
        res_d.end_of_run = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_vld_q <= 1'b0;
      stg_act_q <= 1'b0;
      hits_q    <= '0;
      n_q       <= '0;
      for (int i = 0; i < SET_COUNT; i++) begin
        in_use_q[i] <= 1'b0;
        len_q[i]    <= '0;
      end
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      stg_act_q <= rpt_any.act && (cmd_q.mode == MODE_WAIT);
      hits_q    <= hits_d;
      n_q       <= n_d;
      if (create_we) begin
        in_use_q[free_idx] <= 1'b1;
        len_q[free_idx]    <= '0;
      end
      if (len_inc) begin
        len_q[sidx] <= LW'(cur_len + 1'b1);
      end else if (len_dec) begin
        len_q[sidx] <= LW'(cur_len - 1'b1);
      end
    end
  end

  // hold the item and the wait stage payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= req_i;
    end
    res_q      <= res_d;
    stg_fd_q   <= rpt_any.ent.fd;
    stg_mask_q <= rpt_any.ent.mask;
  end

endmodule

@@ hdl/ric_checker.sv @@
// Port-level checks for readiness_interest_table_core, attached by bind.
// Depends on ric_pkg.
`timescale 1ns / 1ps
module ric_checker import ric_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input res_t res_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_entry_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.has_entry |->
      !res_o.end_of_run && res_o.hit_events != '0 && res_o.status == ST_OK)
    else $error("malformed wait entry result");

  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.status != ST_OK |-> res_o.end_of_run)
    else $error("error result not last of its item");

  a_gap_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.end_of_run |=> !result_valid_o)
    else $error("result right after end of run");

endmodule

bind readiness_interest_table_core ric_checker u_ric_checker (.*);
